>>> hdl/urh_pkg.sv
package urh_pkg;

   // History depth and derived widths
   localparam int DEPTH = 10;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Keystroke codes
   localparam logic [7:0] KEY_UNDO  = 8'h55;
   localparam logic [7:0] KEY_REDO  = 8'h52;
   localparam logic [7:0] KEY_SPACE = 8'h20;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_OK         = 3'd0,
      KIND_ERR        = 3'd1,
      KIND_UNDO_ENTRY = 3'd2,
      KIND_REDO_ENTRY = 3'd3,
      KIND_UNDO_EMPTY = 3'd4,
      KIND_REDO_EMPTY = 3'd5
   } kind_type;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_KEY,
      OP_START,
      OP_DUMP_UNDO,
      OP_DUMP_REDO
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic undo_empty;
      logic redo_empty;
      logic cursor_one;
   } status_type;

endpackage

>>> hdl/urh_ctrl.sv
module urh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  urh_pkg::status_type status,
   output urh_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_KEYS,
      S_UNDO,
      S_REDO
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      slot_free;

   // Output slot is free when empty or being drained this cycle
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_KEYS) && slot_free;
   assign rsp_tvalid = rsp_tvalid_ff;

   // Sequence keystrokes and the dump phases
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd.op        = urh_pkg::OP_NONE;
      case (state_ff)
         S_KEYS: begin
            if (req_tvalid && slot_free) begin
               if (req_tuser) begin
                  cmd.op   = urh_pkg::OP_START;
                  state_in = S_UNDO;
               end else begin
                  cmd.op        = urh_pkg::OP_KEY;
                  rsp_tvalid_in = 1'b1;
               end
            end
         end
         S_UNDO: begin
            if (slot_free) begin
               cmd.op        = urh_pkg::OP_DUMP_UNDO;
               rsp_tvalid_in = 1'b1;
               if (status.undo_empty || status.cursor_one) begin
                  state_in = S_REDO;
               end
            end
         end
         S_REDO: begin
            if (slot_free) begin
               cmd.op        = urh_pkg::OP_DUMP_REDO;
               rsp_tvalid_in = 1'b1;
               if (status.redo_empty || status.cursor_one) begin
                  state_in = S_KEYS;
               end
            end
         end
         default: begin
            state_in = S_KEYS;
         end
      endcase
   end

   // Hold state and the output valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_KEYS;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

>>> hdl/urh_dp.sv
module urh_dp (
   input  logic                clock,
   input  logic                reset,
   input  urh_pkg::cmd_type    cmd,
   input  logic [7:0]          key_byte,
   output urh_pkg::status_type status,
   output logic [2:0]          kind,
   output logic [7:0]          entry,
   output logic                last
);

   localparam int IW = urh_pkg::IDX_W;
   localparam int CW = urh_pkg::CNT_W;

   // Reduce a sum below twice the depth to a ring index
   function automatic logic [IW-1:0] wrap(input logic [CW:0] s);
      logic [CW:0] r;
      begin
         r = (s >= (CW+1)'(urh_pkg::DEPTH)) ? s - (CW+1)'(urh_pkg::DEPTH) : s;
         return r[IW-1:0];
      end
   endfunction

   logic [7:0]    undo_store_ff [urh_pkg::DEPTH];
   logic [7:0]    redo_store_ff [urh_pkg::DEPTH];
   logic [IW-1:0] undo_oldest_ff, undo_oldest_in;
   logic [CW-1:0] undo_count_ff, undo_count_in;
   logic [CW-1:0] redo_count_ff, redo_count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   urh_pkg::kind_type kind_ff, kind_in;
   logic [7:0]    entry_ff, entry_in;
   logic          last_ff, last_in;

   logic          undo_we, redo_we;
   logic [IW-1:0] undo_wr_idx, redo_wr_idx;
   logic [7:0]    undo_wr_data, redo_wr_data;
   logic [CW-1:0] undo_sel, redo_sel;
   logic [IW-1:0] undo_rd_idx, redo_rd_idx;
   logic [7:0]    undo_rd, redo_rd;
   logic          append_en;
   logic [7:0]    append_byte;
   logic          undo_full;
   logic          load;

   assign status.undo_empty = (undo_count_ff == '0);
   assign status.redo_empty = (redo_count_ff == '0);
   assign status.cursor_one = (cursor_ff == CW'(1));

   // Read ports: newest entry for keystrokes, cursor entry while dumping
   assign undo_sel    = (cmd.op == urh_pkg::OP_DUMP_UNDO) ? cursor_ff : undo_count_ff;
   assign redo_sel    = (cmd.op == urh_pkg::OP_DUMP_REDO) ? cursor_ff : redo_count_ff;
   assign undo_rd_idx = wrap((CW+1)'(undo_oldest_ff) + (CW+1)'(undo_sel) - (CW+1)'(1));
   assign redo_rd_idx = IW'(redo_sel - CW'(1));
   assign undo_rd     = undo_store_ff[undo_rd_idx];
   assign redo_rd     = redo_store_ff[redo_rd_idx];

   assign undo_full = (undo_count_ff == CW'(urh_pkg::DEPTH));

   // Next state for stores, counts, cursor and result
   always_comb begin
      undo_oldest_in = undo_oldest_ff;
      undo_count_in  = undo_count_ff;
      redo_count_in  = redo_count_ff;
      cursor_in      = cursor_ff;
      kind_in        = kind_ff;
      entry_in       = entry_ff;
      last_in        = last_ff;
      load           = 1'b0;
      undo_we        = 1'b0;
      undo_wr_idx    = wrap((CW+1)'(undo_oldest_ff) + (CW+1)'(undo_count_ff));
      undo_wr_data   = 8'h00;
      redo_we        = 1'b0;
      redo_wr_idx    = IW'(redo_count_ff);
      redo_wr_data   = undo_rd;
      append_en      = 1'b0;
      append_byte    = key_byte;

      case (cmd.op)
         urh_pkg::OP_KEY: begin
            load     = 1'b1;
            kind_in  = urh_pkg::KIND_OK;
            entry_in = 8'h00;
            last_in  = 1'b1;
            if (key_byte == urh_pkg::KEY_SPACE) begin
               kind_in = urh_pkg::KIND_OK;
            end else if (key_byte == urh_pkg::KEY_UNDO) begin
               if (status.undo_empty || redo_count_ff >= CW'(urh_pkg::DEPTH)) begin
                  kind_in = urh_pkg::KIND_ERR;
               end else begin
                  undo_count_in = undo_count_ff - CW'(1);
                  redo_we       = 1'b1;
                  redo_count_in = redo_count_ff + CW'(1);
               end
            end else if (key_byte == urh_pkg::KEY_REDO) begin
               if (status.redo_empty) begin
                  kind_in = urh_pkg::KIND_ERR;
               end else begin
                  redo_count_in = redo_count_ff - CW'(1);
                  append_en     = 1'b1;
                  append_byte   = redo_rd;
               end
            end else begin
               redo_count_in = '0;
               append_en     = 1'b1;
            end
         end
         urh_pkg::OP_START: begin
            cursor_in = undo_count_ff;
         end
         urh_pkg::OP_DUMP_UNDO: begin
            load    = 1'b1;
            last_in = 1'b0;
            if (status.undo_empty) begin
               kind_in   = urh_pkg::KIND_UNDO_EMPTY;
               entry_in  = 8'h00;
               cursor_in = redo_count_ff;
            end else begin
               kind_in  = urh_pkg::KIND_UNDO_ENTRY;
               entry_in = undo_rd;
               if (status.cursor_one) begin
                  cursor_in = redo_count_ff;
               end else begin
                  cursor_in = cursor_ff - CW'(1);
               end
            end
         end
         urh_pkg::OP_DUMP_REDO: begin
            load = 1'b1;
            if (status.redo_empty) begin
               kind_in  = urh_pkg::KIND_REDO_EMPTY;
               entry_in = 8'h00;
               last_in  = 1'b1;
            end else begin
               kind_in   = urh_pkg::KIND_REDO_ENTRY;
               entry_in  = redo_rd;
               last_in   = status.cursor_one;
               cursor_in = cursor_ff - CW'(1);
            end
            // Empty both stores after the final result
            if (status.redo_empty || status.cursor_one) begin
               undo_count_in  = '0;
               undo_oldest_in = '0;
               redo_count_in  = '0;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase

      // Append to the history ring, evicting the oldest entry when full
      if (append_en) begin
         undo_we      = 1'b1;
         undo_wr_data = append_byte;
         if (undo_full) begin
            undo_wr_idx    = undo_oldest_ff;
            undo_oldest_in = wrap((CW+1)'(undo_oldest_ff) + (CW+1)'(1));
            undo_count_in  = CW'(urh_pkg::DEPTH);
         end else begin
            undo_count_in = undo_count_ff + CW'(1);
         end
      end
   end

   // Write the stores
   always_ff @(posedge clock) begin
      if (undo_we) begin
         undo_store_ff[undo_wr_idx] <= undo_wr_data;
      end
      if (redo_we) begin
         redo_store_ff[redo_wr_idx] <= redo_wr_data;
      end
   end

   // Hold counts and cursor
   always_ff @(posedge clock) begin
      if (reset) begin
         undo_oldest_ff <= '0;
         undo_count_ff  <= '0;
         redo_count_ff  <= '0;
         cursor_ff      <= '0;
      end else begin
         undo_oldest_ff <= undo_oldest_in;
         undo_count_ff  <= undo_count_in;
         redo_count_ff  <= redo_count_in;
         cursor_ff      <= cursor_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         entry_ff <= entry_in;
         last_ff  <= last_in;
      end
   end

   assign kind  = kind_ff;
   assign entry = entry_ff;
   assign last  = last_ff;

endmodule

>>> hdl/undo_redo_history_top.sv
// Bounded undo/redo history of keystroke bytes. A keystroke transaction on req (tuser = 0,
// tdata[7:0] = byte) gives exactly one rsp transaction with tlast set: kind accepted or
// error. 'U' moves the newest history byte onto the redo stack, 'R' moves it back, a space
// does nothing, any other byte clears the redo stack and joins the history, evicting the
// oldest of DEPTH entries when full. An end-of-line transaction (tuser = 1) lists the
// history newest first, then the redo stack top first (an empty marker stands for a store
// with no entries), sets tlast on the final result and empties both stores. Keystrokes can
// be accepted back to back while rsp is drained; a dump emits one result per cycle from the
// single output register while rsp is drained, and req is held off until the dump ends.
// rsp_tdata: [2:0] kind, [10:3] entry, [15:11] zero.
module undo_redo_history_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] kind, [10:3] entry
   output logic        rsp_tlast
);

   urh_pkg::cmd_type    cmd;
   urh_pkg::status_type status;
   logic [2:0]          kind;
   logic [7:0]          entry;

   urh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   urh_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .key_byte (req_tdata),
      .status   (status),
      .kind     (kind),
      .entry    (entry),
      .last     (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {5'b00000, entry, kind};

endmodule

>>> tb/undo_redo_history_top_tb.sv
module undo_redo_history_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One listed or acknowledged result as it should appear on rsp
   typedef struct packed {
      urh_pkg::kind_type kind;
      logic [7:0]        entry;
      logic              last;
   } history_result_type;

   typedef enum {READY_ALWAYS, READY_ALTERNATE, READY_RANDOM, READY_SPARSE} ready_mode_type;

   // Scoreboard: keeps its own copy of the history and redo stack and the results owed
   class history_scoreboard;
      logic [7:0]         undo_ring [urh_pkg::DEPTH];
      int unsigned        undo_oldest_idx;
      int unsigned        undo_cnt;
      logic [7:0]         redo_stack [urh_pkg::DEPTH];
      int unsigned        redo_cnt;
      history_result_type owed_results [$];
      int unsigned        mismatch_cnt;

      function new();
         undo_oldest_idx = 0;
         undo_cnt        = 0;
         redo_cnt        = 0;
         mismatch_cnt    = 0;
      endfunction

      function void owe(urh_pkg::kind_type kind, logic [7:0] entry, logic last);
         history_result_type r;
         r.kind  = kind;
         r.entry = entry;
         r.last  = last;
         owed_results.push_back(r);
      endfunction

      // Append to the history ring, evicting the oldest entry when full
      function void append_history(logic [7:0] b);
         if (undo_cnt >= urh_pkg::DEPTH) begin
            undo_oldest_idx = (undo_oldest_idx + 1) % urh_pkg::DEPTH;
            undo_cnt        = urh_pkg::DEPTH - 1;
         end
         undo_ring[(undo_oldest_idx + undo_cnt) % urh_pkg::DEPTH] = b;
         undo_cnt++;
      endfunction

      // Work out the results of one accepted req transaction and advance the state
      function void note_command(logic cmd, logic [7:0] key);
         int unsigned i;
         if (cmd) begin
            // List history newest first, then redo stack top first; the redo part
            // always emits at least one result, so it carries tlast
            if (undo_cnt == 0) begin
               owe(urh_pkg::KIND_UNDO_EMPTY, 8'h00, 1'b0);
            end else begin
               for (i = undo_cnt; i > 0; i--)
                  owe(urh_pkg::KIND_UNDO_ENTRY,
                      undo_ring[(undo_oldest_idx + i - 1) % urh_pkg::DEPTH], 1'b0);
            end
            if (redo_cnt == 0) begin
               owe(urh_pkg::KIND_REDO_EMPTY, 8'h00, 1'b1);
            end else begin
               for (i = redo_cnt; i > 0; i--)
                  owe(urh_pkg::KIND_REDO_ENTRY, redo_stack[i - 1], i == 1);
            end
            undo_cnt        = 0;
            undo_oldest_idx = 0;
            redo_cnt        = 0;
         end else if (key == urh_pkg::KEY_SPACE) begin
            owe(urh_pkg::KIND_OK, 8'h00, 1'b1);
         end else if (key == urh_pkg::KEY_UNDO) begin
            if (undo_cnt == 0 || redo_cnt >= urh_pkg::DEPTH) begin
               owe(urh_pkg::KIND_ERR, 8'h00, 1'b1);
            end else begin
               redo_stack[redo_cnt] =
                  undo_ring[(undo_oldest_idx + undo_cnt - 1) % urh_pkg::DEPTH];
               undo_cnt--;
               redo_cnt++;
               owe(urh_pkg::KIND_OK, 8'h00, 1'b1);
            end
         end else if (key == urh_pkg::KEY_REDO) begin
            if (redo_cnt == 0) begin
               owe(urh_pkg::KIND_ERR, 8'h00, 1'b1);
            end else begin
               redo_cnt--;
               append_history(redo_stack[redo_cnt]);
               owe(urh_pkg::KIND_OK, 8'h00, 1'b1);
            end
         end else begin
            // Edit: drop the redo stack, then join the history
            redo_cnt = 0;
            append_history(key);
            owe(urh_pkg::KIND_OK, 8'h00, 1'b1);
         end
      endfunction

      // Compare one rsp transaction against the oldest owed result
      function void check_result(logic [15:0] data, logic last);
         history_result_type want;
         if (owed_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: unexpected result kind %0d entry %02h last %0b",
                        $realtime, data[2:0], data[10:3], last);
            return;
         end
         want = owed_results.pop_front();
         if (data[2:0] !== want.kind || data[10:3] !== want.entry ||
             data[15:11] !== 5'd0 || last !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("%0t: mismatch: expected kind %0d entry %02h last %0b, %s",
                        $realtime, want.kind, want.entry, want.last,
                        $sformatf("got kind %0d entry %02h last %0b pad %02h",
                                  data[2:0], data[10:3], last, data[15:11]));
         end
      endfunction

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   history_scoreboard sb = new();

   int unsigned burst_left = 0;
   int unsigned key_count  = 0;

   undo_redo_history_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: runs of always-ready, alternating, random and sparse acceptance
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned    ready_run  = 0;

   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_run  = $urandom_range(4, 40);
      end
      ready_run--;
      case (ready_mode)
         READY_ALWAYS:    rsp_tready <= 1'b1;
         READY_ALTERNATE: rsp_tready <= ~rsp_tready;
         READY_RANDOM:    rsp_tready <= 1'($urandom_range(0, 1));
         default:         rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Check every rsp transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
   end

   // Present one req transaction, idling between bursts, and note it once accepted
   task automatic drive_command(input logic cmd, input logic [7:0] key);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, key);
      if (cmd || key != urh_pkg::KEY_SPACE)
         key_count++;
   endtask

   // Hold off the sender until every owed result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_edit();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == urh_pkg::KEY_UNDO || b == urh_pkg::KEY_REDO || b == urh_pkg::KEY_SPACE);
      return b;
   endfunction

   // Stimulus
   initial begin
      int unsigned n;
      int unsigned pick;
      int unsigned i;
      int unsigned wait_cycles;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty dump, undo and redo on empty stores, space, extreme bytes
      drive_command(1'b1, 8'hFF);
      drive_command(1'b0, urh_pkg::KEY_UNDO);
      drive_command(1'b0, urh_pkg::KEY_REDO);
      drive_command(1'b0, urh_pkg::KEY_SPACE);
      drive_command(1'b0, 8'h00);
      drive_command(1'b0, 8'hFF);
      drive_command(1'b0, urh_pkg::KEY_UNDO);
      drive_command(1'b0, urh_pkg::KEY_UNDO);
      // dump with empty history but redo entries; key byte is ignored
      drive_command(1'b1, urh_pkg::KEY_UNDO);
      // overfill the history to force eviction
      for (i = 0; i < 11; i++)
         drive_command(1'b0, 8'hA0 + i[7:0]);
      drive_command(1'b0, urh_pkg::KEY_UNDO);
      drive_command(1'b0, urh_pkg::KEY_UNDO);
      drive_command(1'b0, urh_pkg::KEY_REDO);
      // edit with redo entries pending clears them; the dump lists a full history
      drive_command(1'b0, 8'h7E);
      drive_command(1'b1, 8'h00);
      drain_results();

      // Random lines, each closed by a dump
      while (key_count < 140) begin
         if ($urandom_range(0, 3) == 0) begin
            // fill, rewind and replay
            n = $urandom_range(8, 14);
            repeat (n) drive_command(1'b0, random_edit());
            n = $urandom_range(0, 11);
            repeat (n) drive_command(1'b0, urh_pkg::KEY_UNDO);
            n = $urandom_range(0, 11);
            repeat (n) drive_command(1'b0, urh_pkg::KEY_REDO);
            if ($urandom_range(0, 1) == 1)
               drive_command(1'b0, random_edit());
         end else begin
            n = $urandom_range(1, 18);
            repeat (n) begin
               pick = $urandom_range(0, 99);
               if (pick < 35)
                  drive_command(1'b0, random_edit());
               else if (pick < 60)
                  drive_command(1'b0, urh_pkg::KEY_UNDO);
               else if (pick < 75)
                  drive_command(1'b0, urh_pkg::KEY_REDO);
               else if (pick < 80)
                  drive_command(1'b0, urh_pkg::KEY_SPACE);
               else if (pick < 97)
                  drive_command(1'b0, 8'($urandom_range(0, 255)));
               else
                  drive_command(1'b1, 8'($urandom_range(0, 255)));
            end
         end
         drive_command(1'b1, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0)
            drain_results();
      end

      // Wait for the tail, then allow the longest dump to show anything extra
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (sb.pending() != 0 && wait_cycles < 50000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (urh_pkg::DEPTH + 4) @(posedge clock);
      if (sb.mismatch_cnt == 0 && sb.pending() == 0)
         $display("undo_redo_history_top_tb: PASS");
      else
         $display("undo_redo_history_top_tb: FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #3000000;
      $display("undo_redo_history_top_tb: FAIL");
      $finish;
   end

endmodule

>>> undo_redo_history_top.f
hdl/urh_pkg.sv
hdl/urh_ctrl.sv
hdl/urh_dp.sv
hdl/undo_redo_history_top.sv
tb/undo_redo_history_top_tb.sv
